@@ rtl/positional_array_list_core_assert.svh @@
// Assertion macros for the RTL of the positional array list core.
`ifndef POSITIONAL_ARRAY_LIST_CORE_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk_i, held off during reset.
`define PAL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("positional_array_list_core: same-cycle check failed");

// Next-cycle implication, checked on clk_i, held off during reset.
`define PAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("positional_array_list_core: next-cycle check failed");

`endif

@@ rtl/pal_pkg.sv @@
`default_nettype none
package pal_pkg;

  localparam int PosW   = 8;
  localparam int ValW   = 32;
  localparam int CountW = 8;
  localparam int OpW    = 2;
  localparam int StW    = 2;

  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_APPEND = 2'd1;
  localparam logic [OpW-1:0] OP_DELETE = 2'd2;
  localparam logic [OpW-1:0] OP_READ   = 2'd3;

  localparam logic [StW-1:0] ST_DONE  = 2'd0;
  localparam logic [StW-1:0] ST_FULL  = 2'd1;
  localparam logic [StW-1:0] ST_RANGE = 2'd2;

endpackage
`default_nettype wire

@@ rtl/positional_array_list_core.sv @@
`default_nettype none
// Positional array list: an ordered list of up to CAPACITY signed 32-bit entries.
// Input channel (in_valid_i / in_stall_o) carries one request item: operation_i
// (insert, append, delete, read), position_i and value_i. Output channel
// (out_valid_o / out_stall_i) carries one result item per request: read_value_o,
// status_o, count_o, empty_res_o and full_res_o. An item moves on a rising edge
// with valid high and stall low.
// Path of a request, for N = count before the request and P = position: append and
// any refused request go straight to the done state; read waits in the read state for
// the RAM; insert moves the N - P entries from the last down to P and then writes the
// new entry; delete reads entry P, then moves the entries after it. The done state
// loads the result register. The list sits in one single-port-write, registered-read
// RAM; insert and delete move each later entry one place through that RAM, one entry a
// cycle with read and write overlapped. One request is worked on at a time and the
// input reopens once the result leaves the sequencer, so a new request is not taken
// before the last one is through the sequencer.
// The input stalls whenever a request is in progress. A finished result waits in
// the output register while the receiver stalls; a new request may be taken
// meanwhile, and its result holds in the sequencer until the register frees.
// Reset empties the list (count zero) and drops any item in flight; the RAM
// contents are not cleared, and only written entries are ever read.
module positional_array_list_core
  import pal_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [OpW-1:0]    operation_i,
  input  wire logic [PosW-1:0]   position_i,
  input  wire logic [ValW-1:0]   value_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [ValW-1:0]   read_value_o,
  output logic      [StW-1:0]    status_o,
  output logic      [CountW-1:0] count_o,
  output logic                   empty_res_o,
  output logic                   full_res_o
);

`include "positional_array_list_core_assert.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > PosW) ? CW : PosW;

  // Sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RDWAIT = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            wr_pend_q, wr_pend_d;

  // Request and walk registers, no reset needed
  logic [OpW-1:0]  op_q, op_d;
  logic [AW-1:0]   pos_q, pos_d;
  logic [ValW-1:0] val_q, val_d;
  logic            up_q, up_d;
  logic [AW-1:0]   rd_addr_q, rd_addr_d;
  logic [AW-1:0]   wr_addr_q, wr_addr_d;
  logic [CW-1:0]   rd_left_q, rd_left_d;
  logic [ValW-1:0] result_q, result_d;
  logic [StW-1:0]  status_q, status_d;

  logic [ValW-1:0]   rv_q, rv_d;
  logic [StW-1:0]    st_q, st_d;
  logic [CountW-1:0] co_q, co_d;
  logic              em_q, em_d;
  logic              fu_q, fu_d;

  // RAM port
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [ValW-1:0] mem_wdata, mem_rdata;

  logic          accept;
  logic          list_full;
  logic [MW-1:0] pos_w, cnt_w;

  assign accept    = in_valid_i && !in_stall_o;
  assign list_full = (cnt_q == CW'(CAPACITY));
  assign pos_w     = MW'(position_i);
  assign cnt_w     = MW'(cnt_q);

  assign in_stall_o = (state_q != S_IDLE);

  pal_ram #(
    .Width (ValW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    wr_pend_d   = wr_pend_q;
    op_d        = op_q;
    pos_d       = pos_q;
    val_d       = val_q;
    up_d        = up_q;
    rd_addr_d   = rd_addr_q;
    wr_addr_d   = wr_addr_q;
    rd_left_d   = rd_left_q;
    result_d    = result_q;
    status_d    = status_q;
    rv_d        = rv_q;
    st_d        = st_q;
    co_d        = co_q;
    em_d        = em_q;
    fu_d        = fu_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = wr_addr_q;
    mem_raddr   = rd_addr_q;
    mem_wdata   = mem_rdata;

    // Free the output register once the receiver takes the item
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d      = operation_i;
          pos_d     = AW'(position_i);
          val_d     = value_i;
          result_d  = '0;
          status_d  = ST_DONE;
          wr_pend_d = 1'b0;
          state_d   = S_DONE;
          case (operation_i)
            OP_INSERT: begin
              if (list_full) begin
                status_d = ST_FULL;
              end else if (pos_w > cnt_w) begin
                status_d = ST_RANGE;
              end else begin
                // Walk from the last entry down to the insert point
                up_d      = 1'b1;
                rd_addr_d = AW'(cnt_q - CW'(1));
                rd_left_d = cnt_q - CW'(position_i);
                state_d   = S_SHIFT;
              end
            end
            OP_APPEND: begin
              if (list_full) begin
                status_d = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cnt_q);
                mem_wdata = value_i;
                cnt_d     = cnt_q + CW'(1);
              end
            end
            default: begin
              if (pos_w >= cnt_w) begin
                status_d = ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(position_i);
                state_d   = S_RDWAIT;
              end
            end
          endcase
        end
      end

      S_RDWAIT: begin
        result_d = mem_rdata;
        if (op_q == OP_DELETE) begin
          // Walk from the entry after the gap up to the last one
          up_d      = 1'b0;
          rd_addr_d = pos_q + AW'(1);
          rd_left_d = cnt_q - CW'(1) - CW'(pos_q);
          state_d   = S_SHIFT;
        end else begin
          state_d = S_DONE;
        end
      end

      S_SHIFT: begin
        // Write back the entry read in the previous cycle
        if (wr_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_q;
          mem_wdata = mem_rdata;
        end
        if (rd_left_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = rd_addr_q;
          wr_pend_d = 1'b1;
          wr_addr_d = up_q ? (rd_addr_q + AW'(1)) : (rd_addr_q - AW'(1));
          rd_addr_d = up_q ? (rd_addr_q - AW'(1)) : (rd_addr_q + AW'(1));
          rd_left_d = rd_left_q - CW'(1);
        end else begin
          wr_pend_d = 1'b0;
          if (!wr_pend_q) begin
            if (up_q) begin
              // Drop the new entry into the opened gap
              mem_we    = 1'b1;
              mem_waddr = pos_q;
              mem_wdata = val_q;
              cnt_d     = cnt_q + CW'(1);
            end else begin
              cnt_d = cnt_q - CW'(1);
            end
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          rv_d        = result_q;
          st_d        = status_q;
          co_d        = CountW'(cnt_q);
          em_d        = (cnt_q == '0);
          fu_d        = list_full;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      wr_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      wr_pend_q   <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    up_q      <= up_d;
    rd_addr_q <= rd_addr_d;
    wr_addr_q <= wr_addr_d;
    rd_left_q <= rd_left_d;
    result_q  <= result_d;
    status_q  <= status_d;
    rv_q      <= rv_d;
    st_q      <= st_d;
    co_q      <= co_d;
    em_q      <= em_d;
    fu_q      <= fu_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rv_q;
  assign status_o     = st_q;
  assign count_o      = co_q;
  assign empty_res_o  = em_q;
  assign full_res_o   = fu_q;

  // The entry count never passes the capacity
  `PAL_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(CAPACITY))
  // An accepted request always leaves the idle state
  `PAL_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE)
  // The RAM is only written in idle by an accepted append
  `PAL_ASSERT_NOW(a_idle_write, (state_q == S_IDLE) && mem_we,
                  accept && (operation_i == OP_APPEND))
  // A pending write-back only exists while walking the list
  `PAL_ASSERT_NOW(a_pend_shift, wr_pend_q, state_q == S_SHIFT)

endmodule
`default_nettype wire

@@ rtl/pal_ram.sv @@
`default_nettype none
module pal_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import pal_pkg::*;

  localparam int CAPACITY     = 128;
  localparam int RANDOM_ITEMS = 1050;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_AFTER   = 400;   // items accepted before the long hold-off
  localparam int HOLD_CYCLES  = 1500;
  localparam int SETTLE_ITEMS = 10;    // items kept at full or empty before a phase ends

  typedef struct packed {
    logic [ValW-1:0]   read_value;
    logic [StW-1:0]    status;
    logic [CountW-1:0] count;
    logic              empty_res;
    logic              full_res;
  } list_result_t;

  typedef struct {
    logic [OpW-1:0]  op;
    logic [PosW-1:0] pos;
    logic [ValW-1:0] val;
    bit              typed;
    list_result_t    res;
  } stim_row_t;

  typedef enum logic [1:0] {MODE_MIX, MODE_FILL, MODE_DRAIN} phase_mode_e;
  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic [OpW-1:0]    req_op    = OP_READ;
  logic [PosW-1:0]   req_pos   = '0;
  logic [ValW-1:0]   req_value = '0;
  logic              out_stall = 1'b0;

  logic              in_stall;
  logic              out_valid;
  logic [ValW-1:0]   res_value;
  logic [StW-1:0]    res_status;
  logic [CountW-1:0] res_count;
  logic              res_empty;
  logic              res_full;

  // Shadow copy of the list, advanced once per accepted item
  logic [ValW-1:0] list_shadow [CAPACITY];
  int              shadow_len = 0;

  list_result_t    pending_results [$];
  stim_row_t       directed_rows [$];
  int              fail_count        = 0;
  int              items_accepted    = 0;
  int              sender_burst_left = 0;
  int              cycle_count       = 0;

  positional_array_list_core #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .operation_i (req_op),
    .position_i  (req_pos),
    .value_i     (req_value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .read_value_o(res_value),
    .status_o    (res_status),
    .count_o     (res_count),
    .empty_res_o (res_empty),
    .full_res_o  (res_full)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hold reset low from the start, release on an edge, never assert again
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Apply one request to the shadow list and return the result item it causes.
  // A full list is refused before the position is looked at.
  function automatic list_result_t apply_request(input logic [OpW-1:0] op,
                                                 input logic [PosW-1:0] pos,
                                                 input logic [ValW-1:0] val);
    list_result_t r;
    int           slot;
    r.read_value = '0;
    r.status     = ST_DONE;
    if (op == OP_INSERT || op == OP_APPEND) begin
      if (shadow_len >= CAPACITY) begin
        r.status = ST_FULL;
      end else if (op == OP_INSERT && int'(pos) > shadow_len) begin
        r.status = ST_RANGE;
      end else begin
        slot = (op == OP_APPEND) ? shadow_len : int'(pos);
        for (int i = shadow_len; i > slot; i--) list_shadow[i] = list_shadow[i-1];
        list_shadow[slot] = val;
        shadow_len++;
      end
    end else if (int'(pos) >= shadow_len) begin
      // covers every delete or read on an empty list
      r.status = ST_RANGE;
    end else begin
      r.read_value = list_shadow[pos];
      if (op == OP_DELETE) begin
        for (int i = int'(pos); i + 1 < shadow_len; i++) list_shadow[i] = list_shadow[i+1];
        shadow_len--;
      end
    end
    r.count     = CountW'(shadow_len);
    r.empty_res = (shadow_len == 0);
    r.full_res  = (shadow_len == CAPACITY);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [ValW-1:0] want,
                                      input logic [ValW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic add_row(input logic [OpW-1:0] op, input logic [PosW-1:0] pos,
                         input logic [ValW-1:0] val);
    stim_row_t row;
    row.op    = op;
    row.pos   = pos;
    row.val   = val;
    row.typed = 1'b0;
    row.res   = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_checked(input logic [OpW-1:0] op, input logic [PosW-1:0] pos,
                             input logic [ValW-1:0] val, input logic [ValW-1:0] rv,
                             input logic [StW-1:0] st, input logic [CountW-1:0] cnt,
                             input logic emp, input logic ful);
    stim_row_t row;
    row.op    = op;
    row.pos   = pos;
    row.val   = val;
    row.typed = 1'b1;
    row.res   = '{read_value: rv, status: st, count: cnt, empty_res: emp, full_res: ful};
    directed_rows.push_back(row);
  endtask

  // Offer one request item and hold it until taken, then log its expected result
  // and pace the sender: bursts of random length with random gaps between them.
  task automatic offer_item(input logic [OpW-1:0] op, input logic [PosW-1:0] pos,
                            input logic [ValW-1:0] val, input bit typed,
                            input list_result_t typed_res);
    list_result_t predicted;
    int           gap;
    in_valid  <= 1'b1;
    req_op    <= op;
    req_pos   <= pos;
    req_value <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = apply_request(op, pos, val);
    pending_results.push_back(typed ? typed_res : predicted);
    items_accepted++;
    if (sender_burst_left > 0) sender_burst_left--;
    if (sender_burst_left == 0) begin
      sender_burst_left = $urandom_range(16, 1);
      gap = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(12, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Draw one random request. Most positions fall in range for the current length,
  // some sit just past the end, the rest span the whole field.
  task automatic pick_request(input phase_mode_e mode, output logic [OpW-1:0] op,
                              output logic [PosW-1:0] pos, output logic [ValW-1:0] val);
    int unsigned roll;
    int          top;
    roll = $urandom_range(99, 0);
    case (mode)
      MODE_FILL: begin
        op = (roll < 40) ? OP_INSERT : (roll < 70) ? OP_APPEND :
             (roll < 80) ? OP_DELETE : OP_READ;
      end
      MODE_DRAIN: begin
        op = (roll < 65) ? OP_DELETE : (roll < 75) ? OP_INSERT :
             (roll < 85) ? OP_APPEND : OP_READ;
      end
      default: begin
        op = OpW'($urandom_range(3, 0));
      end
    endcase
    roll = $urandom_range(99, 0);
    if (roll < 80 && (op == OP_INSERT || shadow_len > 0)) begin
      top = (op == OP_INSERT) ? shadow_len : shadow_len - 1;
      pos = PosW'($urandom_range(top, 0));
    end else if (roll < 90) begin
      pos = PosW'(shadow_len);
    end else begin
      pos = PosW'($urandom_range(255, 0));
    end
    case ($urandom_range(9, 0))
      0:       val = 32'h8000_0000;
      1:       val = 32'h7FFF_FFFF;
      default: val = $urandom;
    endcase
  endtask

  // Compare every result item taken with the oldest expectation
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: status %0d count %0d",
               res_status, res_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_value", want.read_value, res_value);
        check_field("status", ValW'(want.status), ValW'(res_status));
        check_field("count", ValW'(want.count), ValW'(res_count));
        check_field("empty_res", ValW'(want.empty_res), ValW'(res_empty));
        check_field("full_res", ValW'(want.full_res), ValW'(res_full));
      end
    end
  end

  // Receiver: stall on shifting patterns, and once hold off for a long stretch
  // while the sender keeps offering, so that the block fills and stalls its input.
  initial begin : drive_out_stall
    stall_mode_e pattern;
    int          span;
    bit          held_off;
    held_off = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (!held_off && items_accepted >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        held_off = 1'b1;
      end
      pattern = stall_mode_e'($urandom_range(3, 0));
      span    = $urandom_range(200, 20);
      for (int n = 0; n < span; n++) begin
        case (pattern)
          STALL_RANDOM:   out_stall <= ($urandom_range(1, 0) == 1);
          STALL_PERIODIC: out_stall <= (n % 3 == 2);
          STALL_HEAVY:    out_stall <= ($urandom_range(9, 0) < 7);
          default:        out_stall <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  // Give up on a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** positional_array_list_core: FAILED **");
    $finish;
  end

  initial begin : drive_requests
    phase_mode_e     mode;
    logic [OpW-1:0]  op;
    logic [PosW-1:0] pos;
    logic [ValW-1:0] val;
    list_result_t    no_result;
    int              random_sent;
    int              phase_idx;
    int              phase_len;
    int              mix_len;
    int              settle;
    bit              phase_done;

    no_result   = '0;
    random_sent = 0;
    phase_idx   = 0;

    // Empty list: read, delete and insert past the end are out of range
    add_checked(OP_READ,   8'd0,   32'd0,         32'd0, ST_RANGE, 8'd0, 1'b1, 1'b0);
    add_checked(OP_DELETE, 8'd0,   32'd0,         32'd0, ST_RANGE, 8'd0, 1'b1, 1'b0);
    add_checked(OP_INSERT, 8'd1,   32'd5,         32'd0, ST_RANGE, 8'd0, 1'b1, 1'b0);
    // Extreme values in, extreme values back; append ignores its position
    add_checked(OP_INSERT, 8'd0,   32'h8000_0000, 32'd0, ST_DONE,  8'd1, 1'b0, 1'b0);
    add_checked(OP_APPEND, 8'hFF,  32'h7FFF_FFFF, 32'd0, ST_DONE,  8'd2, 1'b0, 1'b0);
    add_checked(OP_READ,   8'd0,   32'd0, 32'h8000_0000, ST_DONE,  8'd2, 1'b0, 1'b0);
    add_checked(OP_READ,   8'd1,   32'd0, 32'h7FFF_FFFF, ST_DONE,  8'd2, 1'b0, 1'b0);
    add_checked(OP_INSERT, 8'd2,   32'hFFFF_FFFF, 32'd0, ST_DONE,  8'd3, 1'b0, 1'b0);
    add_row(OP_INSERT, 8'd1, 32'd0);
    add_row(OP_INSERT, 8'd0, 32'h1234_5678);
    // Positions just past the end and at the top of the field
    add_checked(OP_READ,   8'd5,   32'd0,         32'd0, ST_RANGE, 8'd5, 1'b0, 1'b0);
    add_checked(OP_READ,   8'hFF,  32'd0,         32'd0, ST_RANGE, 8'd5, 1'b0, 1'b0);
    add_checked(OP_INSERT, 8'd6,   32'd9,         32'd0, ST_RANGE, 8'd5, 1'b0, 1'b0);
    add_checked(OP_INSERT, 8'h80,  32'd9,         32'd0, ST_RANGE, 8'd5, 1'b0, 1'b0);
    add_checked(OP_DELETE, 8'd5,   32'd0,         32'd0, ST_RANGE, 8'd5, 1'b0, 1'b0);
    // Delete at the head, at the tail and in the middle
    add_row(OP_DELETE, 8'd0, 32'd0);
    add_row(OP_DELETE, 8'd3, 32'd0);
    add_row(OP_APPEND, 8'd0, 32'd1);
    add_row(OP_DELETE, 8'd1, 32'd0);
    add_row(OP_READ,   8'd2, 32'd0);
    add_row(OP_DELETE, 8'd0, 32'd0);
    add_row(OP_DELETE, 8'd0, 32'd0);
    add_row(OP_DELETE, 8'd0, 32'd0);
    add_checked(OP_DELETE, 8'd0,   32'd0,         32'd0, ST_RANGE, 8'd0, 1'b1, 1'b0);

    do @(posedge clk); while (rst_n !== 1'b1);

    foreach (directed_rows[k]) begin
      offer_item(directed_rows[k].op, directed_rows[k].pos, directed_rows[k].val,
                 directed_rows[k].typed, directed_rows[k].res);
    end

    // Random phases: mixed traffic, fill to full and sit there, mixed, drain to
    // empty and sit there, and round again.
    while (random_sent < RANDOM_ITEMS) begin
      case (phase_idx % 4)
        1:       mode = MODE_FILL;
        3:       mode = MODE_DRAIN;
        default: mode = MODE_MIX;
      endcase
      mix_len    = $urandom_range(80, 30);
      phase_len  = 0;
      settle     = 0;
      phase_done = 1'b0;
      while (!phase_done && random_sent < RANDOM_ITEMS) begin
        pick_request(mode, op, pos, val);
        offer_item(op, pos, val, 1'b0, no_result);
        random_sent++;
        phase_len++;
        case (mode)
          MODE_FILL: begin
            if (shadow_len == CAPACITY) settle++;
            phase_done = (settle >= SETTLE_ITEMS) || (phase_len >= 600);
          end
          MODE_DRAIN: begin
            if (shadow_len == 0) settle++;
            phase_done = (settle >= SETTLE_ITEMS) || (phase_len >= 600);
          end
          default: begin
            phase_done = (phase_len >= mix_len);
          end
        endcase
      end
      phase_idx++;
    end
    in_valid <= 1'b0;

    // Drain: wait for every outstanding result, then allow a full shift's worth
    while (pending_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    if (fail_count == 0) begin
      $display("** positional_array_list_core: PASSED **");
    end else begin
      $display("** positional_array_list_core: FAILED **");
    end
    $finish;
  end

endmodule
